FILE: design/chunked_moving_average_rate_meter_defines.svh
// Assertion macros for the chunked moving average rate meter.
// Used by the top level; expects clk and arst_n in the enclosing module.
`ifndef CHUNKED_MOVING_AVERAGE_RATE_METER_DEFINES_SVH
`define CHUNKED_MOVING_AVERAGE_RATE_METER_DEFINES_SVH
`ifndef SYNTH
`define CMAR_AST_IMP(lbl, a, b, msg) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |-> (b)) else $error(msg);
`define CMAR_AST_NXT(lbl, a, b, msg) lbl: assert property (@(posedge clk) disable iff (!arst_n) \
	(a) |=> (b)) else $error(msg);
`else
`define CMAR_AST_IMP(lbl, a, b, msg)
`define CMAR_AST_NXT(lbl, a, b, msg)
`endif
`endif

FILE: design/cmar_pkg.sv
// Shared types and constants of the chunked moving average rate meter.
// No dependencies.
package cmar_pkg;
	localparam int DIV_NW = 66;
	localparam int DIV_DW = 40;
	localparam int DIV_STEPS = 66;
	localparam logic [29:0] NS_PER_SEC = 30'd1000000000;
	localparam logic [47:0] MAX48 = 48'hFFFF_FFFF_FFFF;
	localparam logic [1:0] REG_CHUNK_LENGTH = 2'd0;
	localparam logic [1:0] REG_CHUNK_COUNT = 2'd1;

	typedef enum logic [4:0] {
		S_CLEAR, S_IDLE, S_SP_M, S_SP_DS, S_SP_DW, S_LOOP,
		S_CU_M1, S_CU_M2, S_CU_ADD, S_CU_DS, S_CU_DW, S_CU_WR,
		S_CL0, S_CL1, S_CA_ADD, S_CA_DS, S_CA_DW, S_SL_DS, S_SL_DW, S_CL_END,
		S_RP0, S_RP1, S_RP2, S_RP3, S_RP4, S_OUT
	} state_t;

	typedef struct packed {
		logic                start;
		logic [DIV_NW-1:0]   dividend;
		logic [DIV_DW-1:0]   divisor;
	} div_req_t;
endpackage

FILE: design/chunked_moving_average_rate_meter.sv
// Top level of the chunked moving average rate meter: sequencer, shared
// multiplier and chunk ring. Depends on cmar_pkg, cmar_div, cmar_ram and the defines header.
//
// Channel  Direction  Handshake              Payload
// in       input      in_valid / in_ready    frame_samples, elapsed_ns
// out      output     out_valid / out_ready  avg_speed, window_full
// cfg      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each division runs on the shared bit-serial divider, and the sequencer holds
// its wait state until the divider reports done.
// After reset every ring entry is swept to zero with in_ready low.
// A result waits in the output register while the next frame is taken.
`include "chunked_moving_average_rate_meter_defines.svh"
module chunked_moving_average_rate_meter #(
	parameter int MAX_CHUNKS = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [19:0] frame_samples,
	input  logic [39:0] elapsed_ns,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [47:0] avg_speed,
	output logic        window_full,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [15:0] cfg_data
);
	localparam int IW = $clog2(MAX_CHUNKS);
	localparam int NW = IW + 1;
	localparam int CW = (NW > 7) ? NW : 7;

	cmar_pkg::state_t state_q, state_d;

	logic [15:0]   len_q;
	logic [6:0]    cnt_cfg_q;
	logic [19:0]   rem_q;
	logic [39:0]   ns_q;
	logic [47:0]   x_q, cur_q, avg_q, diff_q, res_q;
	logic [15:0]   fill_q, w_q, wt_q;
	logic [IW-1:0] cidx_q, oidx_q, nxt_q;
	logic          full_q, neg_q;
	logic [65:0]   acc_q;
	logic [39:0]   den_q;
	logic [65:0]   prod_q;
	logic [NW-1:0] clr_q;
	logic          out_valid_q, out_full_q;
	logic [47:0]   out_avg_q;

	logic [15:0]   len_e, room, w_c;
	logic [NW-1:0] n_e, cinc, oinc;
	logic [IW-1:0] nxt_c, onxt_c;
	logic [CW-1:0] cc_ext;
	logic [47:0]   mul_a, ref_c;
	logic [15:0]   mul_b;
	logic [39:0]   den_c;
	logic          ram_we;
	logic [IW-1:0] ram_addr;
	logic [47:0]   ram_wdata, ram_rdata;
	cmar_pkg::div_req_t div_req;
	logic          div_done;
	logic [65:0]   div_q;
	logic          in_acc, out_load;
	logic          div_wait;

	function automatic logic [47:0] adjust(input logic [47:0] base, input logic [65:0] t,
			input logic neg);
		logic [47:0] r;
		if (!neg) begin
			r = (t > {18'd0, cmar_pkg::MAX48 - base}) ? cmar_pkg::MAX48 : base + t[47:0];
		end else begin
			r = (t > {18'd0, base}) ? 48'd0 : base - t[47:0];
		end
		return r;
	endfunction

	assign cfg_ready = 1'b1;

	always_comb begin
		len_e = (len_q == 16'd0) ? 16'd1 : len_q;
		cc_ext = CW'(cnt_cfg_q);
		if (cc_ext < CW'(2)) begin
			n_e = NW'(2);
		end else if (cc_ext > CW'(MAX_CHUNKS)) begin
			n_e = NW'(MAX_CHUNKS);
		end else begin
			n_e = NW'(cc_ext);
		end
		room = (len_e > fill_q) ? len_e - fill_q : 16'd0;
		w_c = (rem_q < {4'd0, room}) ? rem_q[15:0] : room;
		cinc = {1'b0, cidx_q} + NW'(1);
		nxt_c = (cinc >= n_e) ? '0 : cinc[IW-1:0];
		oinc = {1'b0, oidx_q} + NW'(1);
		onxt_c = (oinc >= n_e) ? '0 : oinc[IW-1:0];
		ref_c = full_q ? ram_rdata : avg_q;
		den_c = full_q ? prod_q[39:0] : prod_q[39:0] + 40'(fill_q);
	end

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			cmar_pkg::S_CLEAR: if (clr_q == NW'(MAX_CHUNKS - 1)) state_d = cmar_pkg::S_IDLE;
			cmar_pkg::S_IDLE:  if (in_valid) state_d = cmar_pkg::S_SP_M;
			cmar_pkg::S_SP_M:  state_d = cmar_pkg::S_SP_DS;
			cmar_pkg::S_SP_DS: state_d = (ns_q == 40'd0) ? cmar_pkg::S_LOOP : cmar_pkg::S_SP_DW;
			cmar_pkg::S_SP_DW: if (div_done) state_d = cmar_pkg::S_LOOP;
			cmar_pkg::S_LOOP: begin
				if (rem_q == 20'd0) begin
					state_d = cmar_pkg::S_RP0;
				end else if (w_c != 16'd0) begin
					state_d = cmar_pkg::S_CU_M1;
				end else begin
					state_d = cmar_pkg::S_CL0;
				end
			end
			cmar_pkg::S_CU_M1:  state_d = cmar_pkg::S_CU_M2;
			cmar_pkg::S_CU_M2:  state_d = cmar_pkg::S_CU_ADD;
			cmar_pkg::S_CU_ADD: state_d = cmar_pkg::S_CU_DS;
			cmar_pkg::S_CU_DS:  state_d = cmar_pkg::S_CU_DW;
			cmar_pkg::S_CU_DW:  if (div_done) state_d = cmar_pkg::S_CU_WR;
			cmar_pkg::S_CU_WR: begin
				state_d = (fill_q >= len_e) ? cmar_pkg::S_CL0 : cmar_pkg::S_LOOP;
			end
			cmar_pkg::S_CL0: state_d = cmar_pkg::S_CL1;
			cmar_pkg::S_CL1: begin
				if (nxt_q == oidx_q) begin
					state_d = cmar_pkg::S_SL_DS;
				end else if (nxt_q == '0) begin
					state_d = cmar_pkg::S_CL_END;
				end else begin
					state_d = cmar_pkg::S_CA_ADD;
				end
			end
			cmar_pkg::S_CA_ADD: state_d = cmar_pkg::S_CA_DS;
			cmar_pkg::S_CA_DS:  state_d = cmar_pkg::S_CA_DW;
			cmar_pkg::S_CA_DW:  if (div_done) state_d = cmar_pkg::S_CL_END;
			cmar_pkg::S_SL_DS:  state_d = cmar_pkg::S_SL_DW;
			cmar_pkg::S_SL_DW:  if (div_done) state_d = cmar_pkg::S_CL_END;
			cmar_pkg::S_CL_END: state_d = cmar_pkg::S_LOOP;
			cmar_pkg::S_RP0:    state_d = cmar_pkg::S_RP1;
			cmar_pkg::S_RP1: begin
				state_d = (!full_q && den_c == 40'd0) ? cmar_pkg::S_OUT : cmar_pkg::S_RP2;
			end
			cmar_pkg::S_RP2: state_d = cmar_pkg::S_RP3;
			cmar_pkg::S_RP3: state_d = cmar_pkg::S_RP4;
			cmar_pkg::S_RP4: if (div_done) state_d = cmar_pkg::S_OUT;
			cmar_pkg::S_OUT: if (!out_valid_q || out_ready) state_d = cmar_pkg::S_IDLE;
			default: state_d = cmar_pkg::S_IDLE;
		endcase
	end

	// Outputs of the sequencer: input ready, multiplier, divider, ring and output load controls.
	always_comb begin
		in_ready = 1'b0;
		mul_a = '0;
		mul_b = '0;
		div_req = '0;
		ram_we = 1'b0;
		ram_addr = oidx_q;
		ram_wdata = '0;
		out_load = 1'b0;
		case (state_q)
			cmar_pkg::S_CLEAR: begin
				ram_we = 1'b1;
				ram_addr = clr_q[IW-1:0];
			end
			cmar_pkg::S_IDLE: in_ready = 1'b1;
			cmar_pkg::S_SP_DS: begin
				div_req.start = (ns_q != 40'd0);
				div_req.dividend = {prod_q[49:0], 16'd0};
				div_req.divisor = ns_q;
			end
			cmar_pkg::S_CU_M1: begin
				mul_a = cur_q;
				mul_b = fill_q;
			end
			cmar_pkg::S_CU_M2: begin
				mul_a = x_q;
				mul_b = w_q;
			end
			cmar_pkg::S_CU_DS: begin
				div_req.start = 1'b1;
				div_req.dividend = acc_q;
				div_req.divisor = 40'(wt_q);
			end
			cmar_pkg::S_CU_WR: begin
				ram_we = 1'b1;
				ram_addr = cidx_q;
				ram_wdata = cur_q;
			end
			cmar_pkg::S_CL1: begin
				mul_a = avg_q;
				mul_b = 16'(nxt_q) - 16'd1;
			end
			cmar_pkg::S_CA_DS: begin
				div_req.start = 1'b1;
				div_req.dividend = acc_q;
				div_req.divisor = 40'(nxt_q);
			end
			cmar_pkg::S_SL_DS: begin
				div_req.start = 1'b1;
				div_req.dividend = 66'(diff_q);
				div_req.divisor = 40'(n_e) - 40'd1;
			end
			cmar_pkg::S_CL_END: begin
				ram_we = 1'b1;
				ram_addr = nxt_q;
			end
			cmar_pkg::S_RP0: begin
				mul_a = 48'(len_e);
				mul_b = full_q ? 16'(n_e) - 16'd1 : 16'(cidx_q);
			end
			cmar_pkg::S_RP2: begin
				mul_a = diff_q;
				mul_b = fill_q;
			end
			cmar_pkg::S_RP3: begin
				div_req.start = 1'b1;
				div_req.dividend = prod_q;
				div_req.divisor = den_q;
			end
			cmar_pkg::S_OUT: out_load = !out_valid_q || out_ready;
			default: ;
		endcase
	end

	assign in_acc = in_valid && in_ready;

	assign div_wait = (state_q == cmar_pkg::S_SP_DW) || (state_q == cmar_pkg::S_CU_DW)
		|| (state_q == cmar_pkg::S_CA_DW) || (state_q == cmar_pkg::S_SL_DW)
		|| (state_q == cmar_pkg::S_RP4);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= cmar_pkg::S_CLEAR;
			clr_q <= '0;
			len_q <= 16'd480;
			cnt_cfg_q <= 7'd16;
			cidx_q <= '0;
			oidx_q <= '0;
			fill_q <= '0;
			cur_q <= '0;
			avg_q <= '0;
			full_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == cmar_pkg::S_CLEAR) begin
				clr_q <= clr_q + NW'(1);
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					cmar_pkg::REG_CHUNK_LENGTH: len_q <= cfg_data;
					cmar_pkg::REG_CHUNK_COUNT:  cnt_cfg_q <= cfg_data[6:0];
					default: ;
				endcase
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				cmar_pkg::S_CU_DW: begin
					if (div_done) begin
						cur_q <= div_q[47:0];
						fill_q <= wt_q;
					end
				end
				cmar_pkg::S_CL1: begin
					if (nxt_q == oidx_q) begin
						full_q <= 1'b1;
					end else if (nxt_q == '0) begin
						avg_q <= cur_q;
					end
				end
				cmar_pkg::S_CA_DW: if (div_done) avg_q <= div_q[47:0];
				cmar_pkg::S_SL_DW: begin
					if (div_done) begin
						avg_q <= adjust(avg_q, div_q, neg_q);
						oidx_q <= onxt_c;
					end
				end
				cmar_pkg::S_CL_END: begin
					fill_q <= '0;
					cidx_q <= nxt_q;
					cur_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// Payload registers of the datapath.
	always_ff @(posedge clk) begin
		// The sample count is scaled by a constant; all other products share one multiplier.
		prod_q <= (state_q == cmar_pkg::S_SP_M) ? 66'(rem_q) * 66'(cmar_pkg::NS_PER_SEC)
			: 66'(mul_a) * 66'(mul_b);
		if (in_acc) begin
			rem_q <= frame_samples;
			ns_q <= elapsed_ns;
		end
		if (out_load) begin
			out_avg_q <= res_q;
			out_full_q <= full_q;
		end
		case (state_q)
			cmar_pkg::S_SP_DS: if (ns_q == 40'd0) x_q <= cmar_pkg::MAX48;
			cmar_pkg::S_SP_DW: begin
				if (div_done) begin
					x_q <= (div_q[65:48] != 18'd0) ? cmar_pkg::MAX48 : div_q[47:0];
				end
			end
			cmar_pkg::S_LOOP: begin
				w_q <= w_c;
				wt_q <= fill_q + w_c;
			end
			cmar_pkg::S_CU_M2:  acc_q <= prod_q;
			cmar_pkg::S_CU_ADD: acc_q <= acc_q + prod_q;
			cmar_pkg::S_CU_DW:  if (div_done) rem_q <= rem_q - 20'(w_q);
			cmar_pkg::S_CL0:    nxt_q <= nxt_c;
			cmar_pkg::S_CL1: begin
				// In the sliding case the closed chunk is compared with the oldest one.
				neg_q <= cur_q < ram_rdata;
				diff_q <= (cur_q < ram_rdata) ? ram_rdata - cur_q : cur_q - ram_rdata;
			end
			cmar_pkg::S_CA_ADD: acc_q <= prod_q + 66'(cur_q);
			cmar_pkg::S_RP1: begin
				neg_q <= cur_q < ref_c;
				diff_q <= (cur_q < ref_c) ? ref_c - cur_q : cur_q - ref_c;
				den_q <= den_c;
				res_q <= '0;
			end
			cmar_pkg::S_RP4: if (div_done) res_q <= adjust(avg_q, div_q, neg_q);
			default: ;
		endcase
	end

	cmar_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (div_req),
		.done     (div_done),
		.quotient (div_q)
	);

	cmar_ram #(
		.WIDTH (48),
		.DEPTH (MAX_CHUNKS)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	assign out_valid = out_valid_q;
	assign avg_speed = out_avg_q;
	assign window_full = out_full_q;

	`CMAR_AST_NXT(a_full_sticky, full_q, full_q, "ring full flag dropped")
	`CMAR_AST_IMP(a_div_done_wait, div_done, div_wait, "divider finished outside a wait state")
	`CMAR_AST_NXT(a_close_clears, state_q == cmar_pkg::S_CL_END, (cur_q == 48'd0 && fill_q == 16'd0), "new chunk not cleared")
	`CMAR_AST_NXT(a_busy_after_accept, in_acc, !in_ready, "request taken while busy")
endmodule

FILE: design/cmar_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
module cmar_ram #(
	parameter int WIDTH = 48,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata_q <= mem[addr];
	end

	assign rdata = rdata_q;
endmodule

FILE: design/cmar_div.sv
// Restoring divider, one quotient bit per cycle.
// Uses cmar_pkg for widths and the request struct.
module cmar_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  cmar_pkg::div_req_t            req,
	output logic                          done,
	output logic [cmar_pkg::DIV_NW-1:0]   quotient
);
	localparam int NW = cmar_pkg::DIV_NW;
	localparam int DW = cmar_pkg::DIV_DW;

	logic          busy_q, done_q;
	logic [6:0]    cnt_q;
	logic [NW-1:0] dvd_q;
	logic [DW-1:0] rem_q, dvs_q;
	logic [DW:0]   rem_sh, rem_sub;
	logic          ge;

	always_comb begin
		rem_sh = {rem_q, dvd_q[NW-1]};
		ge = rem_sh >= {1'b0, dvs_q};
		rem_sub = rem_sh - {1'b0, dvs_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 7'd1;
				if (cnt_q == 7'(cmar_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			dvd_q <= req.dividend;
			dvs_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? rem_sub[DW-1:0] : rem_sh[DW-1:0];
			dvd_q <= {dvd_q[NW-2:0], ge};
		end
	end

	assign done = done_q;
	assign quotient = dvd_q;
endmodule

FILE: sim/testbench.sv
// Self-checking testbench for the chunked moving average rate meter.
// Predicts every average in a behavioral model kept here; depends on cmar_pkg and the RTL.
`timescale 1ns / 1ps
module testbench;
	localparam longint CYCLE_LIMIT = 40000000;

	typedef struct {
		logic [19:0] samples;
		logic [39:0] ns;
	} frame_t;

	typedef struct {
		logic [47:0] avg;
		logic        full;
	} rate_t;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [19:0] frame_samples;
	logic [39:0] elapsed_ns;
	logic        out_valid;
	logic        out_ready;
	logic [47:0] avg_speed;
	logic        window_full;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [1:0]  cfg_index;
	logic [15:0] cfg_data;

	chunked_moving_average_rate_meter u_top (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.frame_samples(frame_samples), .elapsed_ns(elapsed_ns),
		.out_valid(out_valid), .out_ready(out_ready),
		.avg_speed(avg_speed), .window_full(window_full),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
		.cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		clk = 1'b1;
		#10;
		clk = 1'b0;
		#10;
	end

	frame_t frame_q[$];
	rate_t  rate_q[$];
	int     errs = 0;
	longint cycle_n = 0;
	int     in_acc_n = 0;
	int     issued_n = 0;
	int     cfg_acc_n = 0;

	// Behavioral copy of the meter state and its registers.
	bit [15:0] len_reg;
	bit [6:0]  cnt_reg;
	bit [63:0] chunk_mean[64];
	int        oldest_i;
	int        cur_i;
	bit [63:0] fill_r;
	bit [63:0] mean_avg;
	bit        ring_full;

	function automatic bit [63:0] speed_of(bit [63:0] samples, bit [63:0] ns);
		bit [63:0] prod, q, r;
		if (ns == 0)
			return {16'd0, cmar_pkg::MAX48};
		prod = samples * 64'd1000000000;
		q = prod / ns;
		r = prod % ns;
		if (q > 64'hFFFF_FFFF)
			return {16'd0, cmar_pkg::MAX48};
		return (q << 16) + ((r << 16) / ns);
	endfunction

	// base +/- trunc(|a - b| * w / d), saturated to 48 bits.
	function automatic bit [63:0] nudge(bit [63:0] base, bit [63:0] a, bit [63:0] b,
			bit [63:0] w, bit [63:0] d);
		bit [63:0] t;
		if (a >= b) begin
			t = ((a - b) * w) / d;
			return (t > {16'd0, cmar_pkg::MAX48} - base) ? {16'd0, cmar_pkg::MAX48} : base + t;
		end
		t = ((b - a) * w) / d;
		return (t > base) ? 64'd0 : base - t;
	endfunction

	task automatic close_chunk(int n);
		bit [63:0] c;
		int nx;
		c = chunk_mean[cur_i];
		nx = cur_i + 1;
		if (nx >= n)
			nx = 0;
		if (nx == oldest_i) begin
			ring_full = 1'b1;
			mean_avg = nudge(mean_avg, c, chunk_mean[oldest_i], 1, n - 1);
			oldest_i = oldest_i + 1;
			if (oldest_i >= n)
				oldest_i = 0;
		end else if (nx == 0) begin
			mean_avg = c;
		end else begin
			mean_avg = (mean_avg * (nx - 1) + c) / nx;
		end
		fill_r = 0;
		cur_i = nx;
		chunk_mean[nx] = 0;
	endtask

	task automatic predict_frame(logic [19:0] fs, logic [39:0] ns);
		bit [63:0] rem, x, room, w, mu, wt, s, res;
		bit [63:0] len;
		int n;
		rate_t r;
		len = (len_reg == 0) ? 1 : len_reg;
		n = (cnt_reg < 2) ? 2 : ((cnt_reg > 64) ? 64 : cnt_reg);
		rem = fs;
		x = speed_of(fs, ns);
		while (rem > 0) begin
			room = (len > fill_r) ? len - fill_r : 0;
			w = (rem < room) ? rem : room;
			if (w > 0) begin
				mu = chunk_mean[cur_i];
				wt = fill_r + w;
				chunk_mean[cur_i] = (mu * (wt - w) + x * w) / wt;
				fill_r = wt;
				rem = rem - w;
			end
			if (fill_r >= len)
				close_chunk(n);
		end
		if (!ring_full) begin
			s = len * cur_i;
			if (s + fill_r == 0)
				res = 0;
			else
				res = nudge(mean_avg, chunk_mean[cur_i], mean_avg, fill_r, s + fill_r);
		end else begin
			res = nudge(mean_avg, chunk_mean[cur_i], chunk_mean[oldest_i], fill_r, len * (n - 1));
		end
		r.avg = res[47:0];
		r.full = ring_full;
		rate_q.push_back(r);
	endtask

	// Monitor: register writes, accepted frames and results, all at the rising edge.
	always @(posedge clk) begin
		rate_t e;
		cycle_n++;
		if (cycle_n == CYCLE_LIMIT) begin
			$display("DONE: errors detected");
			$finish;
		end else if (arst_n) begin
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == cmar_pkg::REG_CHUNK_LENGTH)
					len_reg = cfg_data;
				else if (cfg_index == cmar_pkg::REG_CHUNK_COUNT)
					cnt_reg = cfg_data[6:0];
				cfg_acc_n++;
			end
			if (in_valid && in_ready) begin
				predict_frame(frame_samples, elapsed_ns);
				in_acc_n++;
			end
			if (out_valid && out_ready) begin
				if (rate_q.size() == 0) begin
					$error("result with no request pending: avg_speed %0d", avg_speed);
					errs++;
				end else begin
					e = rate_q.pop_front();
					if (avg_speed !== e.avg) begin
						$error("avg_speed expected %0d actual %0d", e.avg, avg_speed);
						errs++;
					end
					if (window_full !== e.full) begin
						$error("window_full expected %0d actual %0d", e.full, window_full);
						errs++;
					end
				end
			end
		end
	end

	// Driver: requests go out in bursts separated by random gaps.
	int burst_left = 1;
	int gap_left = 0;
	always @(negedge clk) begin
		frame_t f;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_acc_n == issued_n) begin
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (frame_q.size() > 0) begin
				f = frame_q.pop_front();
				frame_samples <= f.samples;
				elapsed_ns <= f.ns;
				in_valid <= 1'b1;
				issued_n++;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 30);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 40);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: stall behavior switches between several patterns.
	int rx_mode = 0;
	int rx_hold = 0;
	int stall_left = 0;
	always @(negedge clk) begin
		if (rx_hold == 0) begin
			rx_mode = $urandom_range(0, 3);
			rx_hold = $urandom_range(50, 400);
		end else begin
			rx_hold--;
		end
		if (stall_left > 0) begin
			stall_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				2: out_ready <= ($urandom_range(0, 3) == 0);
				default: begin
					out_ready <= 1'b1;
					if ($urandom_range(0, 15) == 0)
						stall_left = $urandom_range(1, 100);
				end
			endcase
		end
	end

	task automatic write_reg(logic [1:0] idx, logic [15:0] data);
		int target;
		target = cfg_acc_n + 1;
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		while (cfg_acc_n != target)
			@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic set_window(int len, int cnt);
		logic [15:0] d;
		d = {9'($urandom_range(0, 511)), 7'(cnt)};
		write_reg(cmar_pkg::REG_CHUNK_LENGTH, 16'(len));
		write_reg(cmar_pkg::REG_CHUNK_COUNT, d);
	endtask

	// Holds off new requests until every result is back and the block has settled.
	task automatic drain();
		while (frame_q.size() != 0 || in_acc_n != issued_n || rate_q.size() != 0)
			@(negedge clk);
		repeat (400) @(negedge clk);
	endtask

	task automatic queue_frame(logic [19:0] s, logic [39:0] ns);
		frame_t f;
		f.samples = s;
		f.ns = ns;
		frame_q.push_back(f);
	endtask

	task automatic add_random(int len);
		int eff, sel;
		logic [19:0] s;
		logic [39:0] ns;
		longint lim;
		eff = (len == 0) ? 1 : len;
		lim = (eff * 4 > 1048575) ? 1048575 : eff * 4;
		sel = $urandom_range(0, 15);
		if (sel == 0)
			s = 0;
		else if (sel < 3)
			s = 20'($urandom_range(0, lim));
		else
			s = 20'($urandom_range(1, (eff * 2 > lim) ? lim : eff * 2));
		sel = $urandom_range(0, 15);
		if (sel == 0)
			ns = 0;
		else if (sel == 1)
			ns = 40'($urandom_range(1, 100));
		else if (sel < 4)
			ns = {8'($urandom_range(0, 255)), $urandom()};
		else
			ns = s * 40'd20833 + 40'($urandom_range(0, 200000));
		queue_frame(s, ns);
	endtask

	initial begin
		int len, cnt;
		arst_n = 1'b0;
		in_valid = 1'b0;
		frame_samples = '0;
		elapsed_ns = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		len_reg = 16'd480;
		cnt_reg = 7'd16;
		foreach (chunk_mean[i])
			chunk_mean[i] = 0;
		oldest_i = 0;
		cur_i = 0;
		fill_r = 0;
		mean_avg = 0;
		ring_full = 1'b0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed part at the reset window: empty frames, zero and tiny time, huge time.
		queue_frame(20'd0, 40'd100);
		queue_frame(20'd0, 40'd0);
		queue_frame(20'd480, 40'd0);
		queue_frame(20'd1, 40'd1);
		queue_frame(20'd100, 40'hFF_FFFF_FFFF);
		queue_frame(20'd240, 40'd5000000);
		for (int i = 0; i < 12; i++)
			queue_frame(20'(480 + i * 37), 40'(10000000 + i * 999));
		queue_frame(20'h0_0003, 40'd62500);
		drain();
		// Largest frame against the widest window.
		set_window(65535, 64);
		queue_frame(20'hF_FFFF, 40'hFF_FFFF_FFFF);
		queue_frame(20'h8_0001, 40'h55_5555_5555);
		drain();
		// Zero length and out of range count; the count change wraps the indexes.
		set_window(0, 0);
		queue_frame(20'd3, 40'd1000);
		queue_frame(20'd1, 40'd0);
		queue_frame(20'd0, 40'd7);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: begin len = 1; cnt = 2; end
				1: begin len = 65535; cnt = 64; end
				2: begin len = 0; cnt = 1; end
				3: begin len = 480; cnt = 127; end
				4: begin len = 3; cnt = 5; end
				default: begin
					len = $urandom_range(1, 2000);
					cnt = $urandom_range(0, 127);
				end
			endcase
			set_window(len, cnt);
			for (int i = 0; i < 250; i++)
				add_random(len);
			drain();
		end

		if (errs == 0 && rate_q.size() == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule
